/* src/nvmeqp_pkg.sv */
// Shared types and constants for the NVMe I/O queue pair engine.
// Holds the operation and result codes and the result word layout; no dependencies.
package nvmeqp_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned SlotW         = 6;
  localparam int unsigned CidW          = 16;
  localparam int unsigned TicksW        = 32;

  localparam logic [TicksW-1:0] TimeoutReset = 32'd1_000_000;

  // Register index carried by paddr[2]; byte offsets within a word are ignored.
  localparam logic [0:0] RegTimeoutTicks = 1'b0;

  typedef enum logic [1:0] {
    OpSubmit = 2'd0,
    OpEntry  = 2'd1,
    OpTick   = 2'd2,
    OpUnused = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KindNothing   = 3'd0,
    KindSubmitted = 3'd1,
    KindForeign   = 3'd2,
    KindOwnDone   = 3'd3,
    KindTimedOut  = 3'd4,
    KindRejected  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ErrSuccess  = 2'd0,
    ErrIo       = 2'd1,
    ErrTimedOut = 2'd2
  } err_e;

  typedef struct packed {
    kind_e              kind;
    logic [SlotW-1:0]   sq_slot;
    logic [CidW-1:0]    command_id;
    logic [7:0]         cmd_opcode;
    logic [31:0]        cmd_nsid;
    logic [63:0]        cmd_prp;
    logic [31:0]        cmd_dword10;
    logic [31:0]        cmd_dword11;
    logic [15:0]        cmd_dword12;
    logic [SlotW-1:0]   doorbell_value;
    logic [14:0]        completion_status;
    err_e               final_error;
  } result_t;

endpackage

/* src/nvme_io_queue_pair_engine.sv */
// Top level of the NVMe I/O queue pair engine: input stage, queue state and result register.
// Depends on nvmeqp_pkg for codes, widths and the result word layout.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per operation: a submit,
//   a completion entry read at the queue head, or a time tick. Every accepted word
//   produces exactly one result word on the output channel (out_valid_o / out_stall_i),
//   kind "nothing" included, in order.
//   A word accepted on the input channel is captured in the input stage, then evaluated against
//   the queue state and written to the result register once that register is free, which raises
//   out_valid_o. Throughput is one word per cycle while the output is not stalled; the queue
//   pointers, phase, command id and tick counter are updated in the same cycle that the result
//   is registered, so consecutive words see each other's effects.
//   When the receiver stalls, the result register holds its word and the input stage
//   holds one more; in_stall_o rises only when both are full and the output is stalled.
//   Reset clears all queue state (phase to one), empties both stages and sets the
//   timeout register to 1000000 ticks. The timeout register is written through the
//   APB port at byte address 0 and should only be written while the engine is idle.
module nvme_io_queue_pair_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Input channel.
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   operation_i,
  input  logic [7:0]   opcode_i,
  input  logic [31:0]  namespace_id_i,
  input  logic [63:0]  start_lba_i,
  input  logic [15:0]  block_count_i,
  input  logic [63:0]  buffer_addr_i,
  input  logic [15:0]  entry_status_raw_i,
  input  logic [15:0]  entry_cid_i,
  // Output channel.
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [2:0]   result_kind_o,
  output logic [5:0]   sq_slot_o,
  output logic [15:0]  command_id_o,
  output logic [7:0]   cmd_opcode_o,
  output logic [31:0]  cmd_nsid_o,
  output logic [63:0]  cmd_prp_o,
  output logic [31:0]  cmd_dword10_o,
  output logic [31:0]  cmd_dword11_o,
  output logic [15:0]  cmd_dword12_o,
  output logic [5:0]   doorbell_value_o,
  output logic [14:0]  completion_status_o,
  output logic [1:0]   final_error_o
);

  localparam int unsigned QUEUE_DEPTH = nvmeqp_pkg::QueueDepthDef;
  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  // Configuration register.
  logic [31:0] timeout_q, timeout_d;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == nvmeqp_pkg::RegTimeoutTicks);

  always_comb begin
    timeout_d = timeout_q;
    if (cfg_wr) begin
      timeout_d = pwdata;
    end
  end

  assign prdata = (paddr[2] == nvmeqp_pkg::RegTimeoutTicks) ? timeout_q : 32'd0;

  // Handshake and stage control.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_ready, s1_adv, in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = s1_valid_q;
    end
  end

  // Input stage payload.
  nvmeqp_pkg::op_e s1_op_q;
  logic [7:0]      s1_opcode_q;
  logic [31:0]     s1_nsid_q;
  logic [63:0]     s1_lba_q;
  logic [15:0]     s1_nlb_q;
  logic [63:0]     s1_buf_q;
  logic [15:0]     s1_raw_q;
  logic [15:0]     s1_ecid_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q     <= nvmeqp_pkg::op_e'(operation_i);
      s1_opcode_q <= opcode_i;
      s1_nsid_q   <= namespace_id_i;
      s1_lba_q    <= start_lba_i;
      s1_nlb_q    <= block_count_i;
      s1_buf_q    <= buffer_addr_i;
      s1_raw_q    <= entry_status_raw_i;
      s1_ecid_q   <= entry_cid_i;
    end
  end

  // Queue state.
  logic [PtrW-1:0] sq_tail_q, sq_tail_d;
  logic [PtrW-1:0] cq_head_q, cq_head_d;
  logic            cq_phase_q, cq_phase_d;
  logic [15:0]     next_cid_q, next_cid_d;
  logic            awaiting_q, awaiting_d;
  logic [15:0]     pending_id_q, pending_id_d;
  logic [31:0]     elapsed_q, elapsed_d;

  logic [PtrW-1:0] tail_inc, head_inc;
  logic [31:0]     elapsed_inc;
  nvmeqp_pkg::result_t res_d, res_q;

  assign tail_inc    = (sq_tail_q == PtrLast) ? '0 : sq_tail_q + 1'b1;
  assign head_inc    = (cq_head_q == PtrLast) ? '0 : cq_head_q + 1'b1;
  assign elapsed_inc = elapsed_q + 32'd1;

  always_comb begin
    sq_tail_d    = sq_tail_q;
    cq_head_d    = cq_head_q;
    cq_phase_d   = cq_phase_q;
    next_cid_d   = next_cid_q;
    awaiting_d   = awaiting_q;
    pending_id_d = pending_id_q;
    elapsed_d    = elapsed_q;
    res_d        = '0;

    unique case (s1_op_q)
      nvmeqp_pkg::OpSubmit: begin
        if (awaiting_q) begin
          res_d.kind = nvmeqp_pkg::KindRejected;
        end else begin
          res_d.kind           = nvmeqp_pkg::KindSubmitted;
          res_d.sq_slot        = nvmeqp_pkg::SlotW'(32'(sq_tail_q));
          res_d.command_id     = next_cid_q;
          res_d.cmd_opcode     = s1_opcode_q;
          res_d.cmd_nsid       = s1_nsid_q;
          res_d.cmd_prp        = s1_buf_q;
          res_d.cmd_dword10    = s1_lba_q[31:0];
          res_d.cmd_dword11    = s1_lba_q[63:32];
          res_d.cmd_dword12    = s1_nlb_q - 16'd1;
          res_d.doorbell_value = nvmeqp_pkg::SlotW'(32'(tail_inc));
          sq_tail_d            = tail_inc;
          next_cid_d           = next_cid_q + 16'd1;
          awaiting_d           = 1'b1;
          pending_id_d         = next_cid_q;
          elapsed_d            = '0;
        end
      end
      nvmeqp_pkg::OpEntry: begin
        // Only an entry whose phase matches the expected phase is new.
        if (awaiting_q && (s1_raw_q[0] == cq_phase_q)) begin
          cq_head_d            = head_inc;
          if (cq_head_q == PtrLast) begin
            cq_phase_d = !cq_phase_q;
          end
          res_d.doorbell_value = nvmeqp_pkg::SlotW'(32'(head_inc));
          res_d.command_id     = s1_ecid_q;
          if (s1_ecid_q != pending_id_q) begin
            res_d.kind = nvmeqp_pkg::KindForeign;
          end else begin
            res_d.kind              = nvmeqp_pkg::KindOwnDone;
            res_d.completion_status = s1_raw_q[15:1];
            res_d.final_error       = (|s1_raw_q[15:1]) ? nvmeqp_pkg::ErrIo
                                                        : nvmeqp_pkg::ErrSuccess;
            awaiting_d              = 1'b0;
          end
        end
      end
      nvmeqp_pkg::OpTick: begin
        if (awaiting_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= timeout_q) begin
            res_d.kind        = nvmeqp_pkg::KindTimedOut;
            res_d.command_id  = pending_id_q;
            res_d.final_error = nvmeqp_pkg::ErrTimedOut;
            awaiting_d        = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= nvmeqp_pkg::TimeoutReset;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      sq_tail_q    <= '0;
      cq_head_q    <= '0;
      cq_phase_q   <= 1'b1;
      next_cid_q   <= '0;
      awaiting_q   <= 1'b0;
      pending_id_q <= '0;
      elapsed_q    <= '0;
    end else begin
      timeout_q   <= timeout_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        sq_tail_q    <= sq_tail_d;
        cq_head_q    <= cq_head_d;
        cq_phase_q   <= cq_phase_d;
        next_cid_q   <= next_cid_d;
        awaiting_q   <= awaiting_d;
        pending_id_q <= pending_id_d;
        elapsed_q    <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = res_q.kind;
  assign sq_slot_o           = res_q.sq_slot;
  assign command_id_o        = res_q.command_id;
  assign cmd_opcode_o        = res_q.cmd_opcode;
  assign cmd_nsid_o          = res_q.cmd_nsid;
  assign cmd_prp_o           = res_q.cmd_prp;
  assign cmd_dword10_o       = res_q.cmd_dword10;
  assign cmd_dword11_o       = res_q.cmd_dword11;
  assign cmd_dword12_o       = res_q.cmd_dword12;
  assign doorbell_value_o    = res_q.doorbell_value;
  assign completion_status_o = res_q.completion_status;
  assign final_error_o       = res_q.final_error;

`ifndef SYNTHESIS
  // A submit leaves a command in flight with a fresh tick count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && res_d.kind == nvmeqp_pkg::KindSubmitted) |=> (awaiting_q && elapsed_q == '0))
    else $error("submit did not start waiting for its completion");

  // Finishing or timing out the command ends the wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (res_d.kind == nvmeqp_pkg::KindOwnDone
                || res_d.kind == nvmeqp_pkg::KindTimedOut)) |=> !awaiting_q)
    else $error("command still awaited after completion or timeout");

  // Only a submitted word carries a submission entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o != nvmeqp_pkg::KindSubmitted)
      |-> (cmd_prp_o == '0 && cmd_dword12_o == '0 && sq_slot_o == '0))
    else $error("submission fields set on a non-submit result");

  // A rejected or no-op word never moves the queue pointers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (res_d.kind == nvmeqp_pkg::KindRejected
                || res_d.kind == nvmeqp_pkg::KindNothing))
      |=> ($stable(sq_tail_q) && $stable(cq_head_q) && $stable(cq_phase_q)))
    else $error("queue pointers moved on a rejected or empty result");
`endif

endmodule

/* tb/nvme_io_queue_pair_checker.sv */
// Checker for the NVMe I/O queue pair engine: watches the input, output and APB channels,
// predicts each result word from its own copy of the queue state and compares field by field.
// Depends on nvmeqp_pkg for the operation, result and error codes.
`timescale 1ns / 1ps

module nvme_io_queue_pair_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        opcode_i,
  input  logic [31:0]       namespace_id_i,
  input  logic [63:0]       start_lba_i,
  input  logic [15:0]       block_count_i,
  input  logic [63:0]       buffer_addr_i,
  input  logic [15:0]       entry_status_raw_i,
  input  logic [15:0]       entry_cid_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [2:0]        result_kind_o,
  input  logic [5:0]        sq_slot_o,
  input  logic [15:0]       command_id_o,
  input  logic [7:0]        cmd_opcode_o,
  input  logic [31:0]       cmd_nsid_o,
  input  logic [63:0]       cmd_prp_o,
  input  logic [31:0]       cmd_dword10_o,
  input  logic [31:0]       cmd_dword11_o,
  input  logic [15:0]       cmd_dword12_o,
  input  logic [5:0]        doorbell_value_o,
  input  logic [14:0]       completion_status_o,
  input  logic [1:0]        final_error_o,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  logic [nvmeqp_pkg::SlotW-1:0]  tail_slot;
  logic [nvmeqp_pkg::SlotW-1:0]  head_slot;
  logic                          exp_phase;
  logic [nvmeqp_pkg::CidW-1:0]   cid_counter;
  logic                          busy;
  logic [nvmeqp_pkg::CidW-1:0]   awaited_cid;
  logic [nvmeqp_pkg::TicksW-1:0] tick_count;
  logic [nvmeqp_pkg::TicksW-1:0] tmo_limit;
  nvmeqp_pkg::result_t           expected_results[$];
  int unsigned                   result_index = 0;
  int unsigned                   fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string what);
    if (fail_count < 100) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d, %s: got %0h, expected %0h",
                                result_index, name, got, want));
  endtask

  task automatic compare_result(input nvmeqp_pkg::result_t want);
    check_field("result_kind", 64'(result_kind_o), 64'(want.kind));
    check_field("sq_slot", 64'(sq_slot_o), 64'(want.sq_slot));
    check_field("command_id", 64'(command_id_o), 64'(want.command_id));
    check_field("cmd_opcode", 64'(cmd_opcode_o), 64'(want.cmd_opcode));
    check_field("cmd_nsid", 64'(cmd_nsid_o), 64'(want.cmd_nsid));
    check_field("cmd_prp", cmd_prp_o, want.cmd_prp);
    check_field("cmd_dword10", 64'(cmd_dword10_o), 64'(want.cmd_dword10));
    check_field("cmd_dword11", 64'(cmd_dword11_o), 64'(want.cmd_dword11));
    check_field("cmd_dword12", 64'(cmd_dword12_o), 64'(want.cmd_dword12));
    check_field("doorbell_value", 64'(doorbell_value_o), 64'(want.doorbell_value));
    check_field("completion_status", 64'(completion_status_o), 64'(want.completion_status));
    check_field("final_error", 64'(final_error_o), 64'(want.final_error));
    result_index++;
  endtask

  // Works out the result of one accepted word and advances the queue state.
  function automatic nvmeqp_pkg::result_t queue_pair_result(
    input logic [1:0]  op,
    input logic [7:0]  opc,
    input logic [31:0] nsid,
    input logic [63:0] lba,
    input logic [15:0] nblk,
    input logic [63:0] prp,
    input logic [15:0] raw,
    input logic [15:0] ecid
  );
    nvmeqp_pkg::result_t r;
    r = '0;
    case (op)
      nvmeqp_pkg::OpSubmit: begin
        if (busy) begin
          r.kind = nvmeqp_pkg::KindRejected;
        end else begin
          r.kind        = nvmeqp_pkg::KindSubmitted;
          r.sq_slot     = tail_slot;
          r.command_id  = cid_counter;
          r.cmd_opcode  = opc;
          r.cmd_nsid    = nsid;
          r.cmd_prp     = prp;
          r.cmd_dword10 = lba[31:0];
          r.cmd_dword11 = lba[63:32];
          r.cmd_dword12 = nblk - 16'd1;
          tail_slot     = tail_slot + 1'b1;
          r.doorbell_value = tail_slot;
          awaited_cid   = cid_counter;
          cid_counter   = cid_counter + 1'b1;
          busy          = 1'b1;
          tick_count    = '0;
        end
      end
      nvmeqp_pkg::OpEntry: begin
        // Entries only count while a command is awaited and the phase bit is current.
        if (busy && raw[0] == exp_phase) begin
          head_slot = head_slot + 1'b1;
          if (head_slot == '0) exp_phase = ~exp_phase;
          r.doorbell_value = head_slot;
          r.command_id     = ecid;
          if (ecid != awaited_cid) begin
            r.kind = nvmeqp_pkg::KindForeign;
          end else begin
            r.kind              = nvmeqp_pkg::KindOwnDone;
            r.completion_status = raw[15:1];
            r.final_error       = (raw[15:1] != '0) ? nvmeqp_pkg::ErrIo
                                                    : nvmeqp_pkg::ErrSuccess;
            busy                = 1'b0;
          end
        end
      end
      nvmeqp_pkg::OpTick: begin
        if (busy) begin
          tick_count = tick_count + 1'b1;
          if (tick_count >= tmo_limit) begin
            r.kind        = nvmeqp_pkg::KindTimedOut;
            r.command_id  = awaited_cid;
            r.final_error = nvmeqp_pkg::ErrTimedOut;
            busy          = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_slot   = '0;
      head_slot   = '0;
      exp_phase   = 1'b1;
      cid_counter = '0;
      busy        = 1'b0;
      awaited_cid = '0;
      tick_count  = '0;
      tmo_limit   = nvmeqp_pkg::TimeoutReset;
      expected_results.delete();
      pending_o   = 0;
    end else begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_results.size() == 0) report_mismatch("result word with nothing expected");
        else compare_result(expected_results.pop_front());
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0)
        expected_results.push_back(queue_pair_result(operation_i, opcode_i, namespace_id_i,
          start_lba_i, block_count_i, buffer_addr_i, entry_status_raw_i, entry_cid_i));
      if (psel && penable && pready === 1'b1) begin
        if (pwrite && paddr[2] == nvmeqp_pkg::RegTimeoutTicks) begin
          tmo_limit = pwdata;
        end else if (!pwrite && prdata !== tmo_limit) begin
          report_mismatch($sformatf("timeout register read %0h, expected %0h", prdata, tmo_limit));
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/tb_nvme_io_queue_pair_engine.sv */
// Testbench top for the NVMe I/O queue pair engine: clock, reset, APB setup and word stimulus.
// Depends on nvmeqp_pkg, the engine RTL and nvme_io_queue_pair_checker for all checking.
`timescale 1ns / 1ps

module tb_nvme_io_queue_pair_engine ();

  localparam int unsigned HoldCycles = 300;

  typedef struct {
    nvmeqp_pkg::op_e op;
    logic [7:0]      opc;
    logic [31:0]     nsid;
    logic [63:0]     lba;
    logic [15:0]     nblk;
    logic [63:0]     prp;
    logic [15:0]     raw;
    logic [15:0]     ecid;
  } host_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [7:0]  opcode_i;
  logic [31:0] namespace_id_i;
  logic [63:0] start_lba_i;
  logic [15:0] block_count_i;
  logic [63:0] buffer_addr_i;
  logic [15:0] entry_status_raw_i;
  logic [15:0] entry_cid_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  result_kind_o;
  logic [5:0]  sq_slot_o;
  logic [15:0] command_id_o;
  logic [7:0]  cmd_opcode_o;
  logic [31:0] cmd_nsid_o;
  logic [63:0] cmd_prp_o;
  logic [31:0] cmd_dword10_o;
  logic [31:0] cmd_dword11_o;
  logic [15:0] cmd_dword12_o;
  logic [5:0]  doorbell_value_o;
  logic [14:0] completion_status_o;
  logic [1:0]  final_error_o;

  int unsigned fail_count;
  int unsigned pending_words;

  // Stimulus-side view of the queue state, used only to steer words toward useful cases.
  logic                          plan_busy;
  logic [nvmeqp_pkg::CidW-1:0]   plan_cid;
  logic [nvmeqp_pkg::CidW-1:0]   plan_next;
  logic                          plan_phase;
  logic [nvmeqp_pkg::SlotW-1:0]  plan_head;
  logic [nvmeqp_pkg::TicksW-1:0] plan_ticks;
  logic [nvmeqp_pkg::TicksW-1:0] plan_tmo;
  int unsigned                   effective_words;
  bit                            idle_on;
  bit                            hold_req;
  bit                            hold_done;

  nvme_io_queue_pair_engine u_top (.*);

  nvme_io_queue_pair_checker u_checker (
    .*,
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off that lets the engine back up.
  initial begin
    out_stall_i <= 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  function automatic host_word_t rand_word();
    host_word_t w;
    w.op   = nvmeqp_pkg::op_e'($urandom_range(0, 3));
    w.opc  = 8'($urandom);
    w.nsid = $urandom;
    w.lba  = {$urandom, $urandom};
    w.nblk = 16'($urandom);
    w.prp  = {$urandom, $urandom};
    w.raw  = 16'($urandom);
    w.ecid = 16'($urandom);
    return w;
  endfunction

  // Returns whether the word is a submit or changes the queue state at the engine.
  function automatic bit plan_word(input host_word_t w);
    bit moved;
    moved = 1'b0;
    case (w.op)
      nvmeqp_pkg::OpSubmit: begin
        moved = 1'b1;
        if (!plan_busy) begin
          plan_busy  = 1'b1;
          plan_cid   = plan_next;
          plan_next  = plan_next + 1'b1;
          plan_ticks = '0;
        end
      end
      nvmeqp_pkg::OpEntry: begin
        if (plan_busy && w.raw[0] == plan_phase) begin
          moved     = 1'b1;
          plan_head = plan_head + 1'b1;
          if (plan_head == '0) plan_phase = ~plan_phase;
          if (w.ecid == plan_cid) plan_busy = 1'b0;
        end
      end
      nvmeqp_pkg::OpTick: begin
        if (plan_busy) begin
          moved      = 1'b1;
          plan_ticks = plan_ticks + 1'b1;
          if (plan_ticks >= plan_tmo) plan_busy = 1'b0;
        end
      end
      default: ;
    endcase
    return moved;
  endfunction

  task automatic send_word(input host_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    if (plan_word(w)) effective_words++;
    operation_i        <= w.op;
    opcode_i           <= w.opc;
    namespace_id_i     <= w.nsid;
    start_lba_i        <= w.lba;
    block_count_i      <= w.nblk;
    buffer_addr_i      <= w.prp;
    entry_status_raw_i <= w.raw;
    entry_cid_i        <= w.ecid;
    in_valid_i         <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {nvmeqp_pkg::RegTimeoutTicks, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) plan_tmo = data;
    @(posedge clk_i);
  endtask

  task automatic set_timeout(input logic [31:0] ticks);
    settle();
    apb_access(1'b1, ticks);
    apb_access(1'b0, '0);
  endtask

  task automatic send_op(input nvmeqp_pkg::op_e op);
    host_word_t w;
    w    = rand_word();
    w.op = op;
    send_word(w);
  endtask

  task automatic send_entry(input logic [14:0] status, input logic phase, input logic [15:0] cid);
    host_word_t w;
    w      = rand_word();
    w.op   = nvmeqp_pkg::OpEntry;
    w.raw  = {status, phase};
    w.ecid = cid;
    send_word(w);
  endtask

  task automatic send_submit(input logic [7:0] opc, input logic [31:0] nsid,
                             input logic [63:0] lba, input logic [15:0] nblk,
                             input logic [63:0] prp);
    host_word_t w;
    w      = rand_word();
    w.op   = nvmeqp_pkg::OpSubmit;
    w.opc  = opc;
    w.nsid = nsid;
    w.lba  = lba;
    w.nblk = nblk;
    w.prp  = prp;
    send_word(w);
  endtask

  task automatic run_directed();
    // Nothing is awaited yet, so entries and ticks have no effect.
    send_op(nvmeqp_pkg::OpTick);
    send_entry(15'h1234, plan_phase, 16'h0000);
    send_op(nvmeqp_pkg::OpUnused);
    send_submit(8'h01, '1, '1, 16'hFFFF, '1);
    send_op(nvmeqp_pkg::OpSubmit);
    send_entry(15'h7FFF, ~plan_phase, plan_cid);
    send_entry(15'h0000, plan_phase, ~plan_cid);
    send_op(nvmeqp_pkg::OpTick);
    send_op(nvmeqp_pkg::OpUnused);
    send_entry(15'h0000, plan_phase, plan_cid);
    // A zero block count wraps dword12 to all ones.
    send_submit(8'h02, '0, '0, 16'h0000, '0);
    send_entry(15'h7FFF, plan_phase, plan_cid);
    send_submit(8'hFF, 32'h8000_0001, 64'h0000_0000_FFFF_FFFF, 16'h0001,
                64'h8000_0000_0000_0001);
    send_entry(15'h0001, plan_phase, plan_cid);
    set_timeout(32'd1);
    send_submit(8'h01, 32'h1, 64'hFFFF_FFFF_0000_0000, 16'h0002, 64'h1000);
    send_op(nvmeqp_pkg::OpTick);
    send_entry(15'h0000, plan_phase, plan_cid);
    // A zero limit expires on the very first tick.
    set_timeout(32'd0);
    send_submit(8'h02, 32'h2, 64'h10, 16'h0008, 64'h2000);
    send_op(nvmeqp_pkg::OpTick);
  endtask

  task automatic run_traffic(input int unsigned n);
    host_word_t  w;
    int unsigned stop_at;
    stop_at = effective_words + n;
    while (effective_words < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(rand_word());
      end else begin
        w    = rand_word();
        w.op = nvmeqp_pkg::OpSubmit;
        if ($urandom_range(0, 3) != 0) w.opc = 8'($urandom_range(1, 2));
        if ($urandom_range(0, 3) == 0) w.nblk = 16'($urandom_range(0, 8));
        send_word(w);
        repeat ($urandom_range(0, 5)) begin
          w = rand_word();
          case ($urandom_range(0, 5))
            0, 1: begin
              w.op     = nvmeqp_pkg::OpEntry;
              w.raw[0] = plan_phase;
              if (w.ecid == plan_cid) w.ecid[0] = ~w.ecid[0];
            end
            2: begin
              w.op     = nvmeqp_pkg::OpEntry;
              w.raw[0] = ~plan_phase;
            end
            3: w.op = nvmeqp_pkg::OpTick;
            4: w.op = nvmeqp_pkg::OpSubmit;
            default: w.op = nvmeqp_pkg::OpUnused;
          endcase
          send_word(w);
        end
        if (plan_tmo <= 32'd16 && $urandom_range(0, 2) == 0) begin
          while (plan_busy) send_op(nvmeqp_pkg::OpTick);
        end else begin
          w        = rand_word();
          w.op     = nvmeqp_pkg::OpEntry;
          w.ecid   = plan_cid;
          w.raw[0] = plan_phase;
          if ($urandom_range(0, 1) == 0) w.raw[15:1] = '0;
          send_word(w);
        end
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_valid_i         <= 1'b0;
    operation_i        <= '0;
    opcode_i           <= '0;
    namespace_id_i     <= '0;
    start_lba_i        <= '0;
    block_count_i      <= '0;
    buffer_addr_i      <= '0;
    entry_status_raw_i <= '0;
    entry_cid_i        <= '0;
    plan_busy       = 1'b0;
    plan_cid        = '0;
    plan_next       = '0;
    plan_phase      = 1'b1;
    plan_head       = '0;
    plan_ticks      = '0;
    plan_tmo        = nvmeqp_pkg::TimeoutReset;
    effective_words = 0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, '0);
    set_timeout(nvmeqp_pkg::TimeoutReset);
    run_directed();

    set_timeout(32'hFFFF_FFFF);
    hold_req = 1'b1;
    run_traffic(110);
    set_timeout(32'd3);
    run_traffic(110);
    set_timeout(32'd1);
    run_traffic(110);
    set_timeout(nvmeqp_pkg::TimeoutReset);
    run_traffic(110);
    set_timeout(32'd8);
    idle_on = 1'b0;
    run_traffic(110);
    settle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/nvmeqp_pkg.sv
src/nvme_io_queue_pair_engine.sv
tb/nvme_io_queue_pair_checker.sv
tb/tb_nvme_io_queue_pair_engine.sv
